>>> rtl/rotation_matrix_to_quaternion_macros.svh
// Assertion macros shared by the rotation matrix to quaternion RTL
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RMQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rmq_pkg.sv
// Package: defaults and component slot codes for the matrix to quaternion block
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int EW_DEFAULT = 16;
    localparam int FB_DEFAULT = 14;

    // Quaternion component, in output order
    typedef enum logic [1:0] {
        SLOT_W = 2'd0,
        SLOT_X = 2'd1,
        SLOT_Y = 2'd2,
        SLOT_Z = 2'd3
    } slot_t;

endpackage

>>> rtl/rotation_matrix_to_quaternion.sv
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata: m_r0c0..m_r2c2, lowest first
// m_*      | out | m_tvalid/m_tready  | m_tdata: quat_w,x,y,z; m_tuser: degenerate
// Stages: input register, preparation, RW square root digit stages, DW restoring
// divider stages (one bit per stage each), output. One item enters per cycle
// while the output is not stalled; the one-bit stages set the latency, not the rate.
// rst_n clears the valid bits only. A stalled output holds the whole pipeline;
// s_tready is high whenever the output register is empty or being taken.
`timescale 1ns / 1ps

`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int ELEMENT_WIDTH = EW_DEFAULT,
    parameter int FRACTION_BITS = FB_DEFAULT,
    localparam int IN_W  = ((9 * ELEMENT_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((4 * ELEMENT_WIDTH + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // m_r0c0, m_r0c1, ... m_r2c2, then zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // quat_w, quat_x, quat_y, quat_z, then zero pad
    output logic             m_tuser    // degenerate
);

    localparam int EW  = ELEMENT_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int AW  = ((EW > FB) ? EW : FB) + 3;
    localparam int NW  = AW + FB;
    localparam int RW  = (NW + 1) / 2;
    localparam int NP  = 2 * RW;
    localparam int SRW = RW + 3;
    localparam int MW  = EW + 1;
    localparam int VS  = EW + 2;
    localparam int DW  = MW + FB;
    localparam int VW  = RW + 1;
    localparam int XW  = (DW > RW) ? DW : RW;
    localparam logic [XW-1:0] MAXPOS = (XW'(1) << (EW - 1)) - XW'(1);
    localparam logic [XW-1:0] MAXNEG = XW'(1) << (EW - 1);

    typedef struct packed {
        slot_t             ms;
        logic              degen;
        logic [2:0]        neg;
        logic [3*MW-1:0]   mag;
    } sq_side_t;

    typedef struct packed {
        slot_t             ms;
        logic              degen;
        logic [2:0]        neg;
        logic [RW-1:0]     root;
    } dv_side_t;

    function automatic logic [EW-1:0] sat_val(input logic neg, input logic [XW-1:0] mag);
        logic [XW-1:0] m;
        m = mag;
        if (neg)
        begin
            if (m > MAXNEG)
                m = MAXNEG;
            return EW'(~m + XW'(1));
        end
        if (m > MAXPOS)
            m = MAXPOS;
        return m[EW-1:0];
    endfunction

    logic ce;

    // Input register
    logic                 in_vld_reg;
    logic signed [EW-1:0] mat_reg [9];

    // Preparation stage
    logic              p_vld_reg;
    logic [AW-1:0]     p_a_reg;
    sq_side_t          p_side_reg;
    logic [AW-1:0]     p_a_next;
    sq_side_t          p_side_next;

    // Square root stages
    logic              sq_vld_reg  [RW];
    logic [NP-1:0]     sq_n_reg    [RW];
    logic [SRW-1:0]    sq_rem_reg  [RW];
    logic [RW-1:0]     sq_root_reg [RW];
    sq_side_t          sq_side_reg [RW];
    logic [NP-1:0]     sq_n_next    [RW];
    logic [SRW-1:0]    sq_rem_next  [RW];
    logic [RW-1:0]     sq_root_next [RW];

    // Divider stages, three lanes
    logic              dv_vld_reg  [DW];
    dv_side_t          dv_side_reg [DW];
    logic [DW-1:0]     dv_num_reg  [DW][3];
    logic [VW:0]       dv_rem_reg  [DW][3];
    logic [DW-1:0]     dv_quo_reg  [DW][3];
    dv_side_t          dv_side_next [DW];
    logic [DW-1:0]     dv_num_next  [DW][3];
    logic [VW:0]       dv_rem_next  [DW][3];
    logic [DW-1:0]     dv_quo_next  [DW][3];

    // Output register
    logic              out_vld_reg;
    logic [4*EW-1:0]   out_data_reg;
    logic              out_user_reg;
    logic [4*EW-1:0]   out_data_next;

    assign ce       = !out_vld_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'(out_data_reg);
    assign m_tuser  = out_user_reg;

    // Preparation: branch choice, square root argument, numerators
    always_comb
    begin
        logic signed [AW-1:0] trace;
        logic signed [AW-1:0] one;
        logic signed [AW-1:0] a_alt;
        logic signed [AW-1:0] d0;
        logic signed [AW-1:0] d1;
        logic signed [AW-1:0] d2;
        logic signed [EW-1:0] dmax;
        logic signed [VS-1:0] v [3];
        logic signed [VS-1:0] av;
        logic [1:0]           i;

        d0    = AW'(mat_reg[0]);
        d1    = AW'(mat_reg[4]);
        d2    = AW'(mat_reg[8]);
        one   = AW'(1) <<< FB;
        trace = d0 + d1 + d2;
        a_alt = '0;
        i     = 2'd0;
        dmax  = mat_reg[0];
        if (mat_reg[4] > mat_reg[0])
        begin
            i    = 2'd1;
            dmax = mat_reg[4];
        end
        if (mat_reg[8] > dmax)
            i = 2'd2;

        p_side_next.degen = 1'b0;
        if (trace > 0)
        begin
            p_a_next         = trace + one;
            p_side_next.ms   = SLOT_W;
            v[0] = VS'(mat_reg[5]) - VS'(mat_reg[7]);
            v[1] = VS'(mat_reg[6]) - VS'(mat_reg[2]);
            v[2] = VS'(mat_reg[1]) - VS'(mat_reg[3]);
        end
        else
        begin
            case (i)
                2'd0:
                begin
                    a_alt          = d0 - (d1 + d2) + one;
                    p_side_next.ms = SLOT_X;
                    v[0] = VS'(mat_reg[5]) - VS'(mat_reg[7]);
                    v[1] = VS'(mat_reg[1]) + VS'(mat_reg[3]);
                    v[2] = VS'(mat_reg[2]) + VS'(mat_reg[6]);
                end
                2'd1:
                begin
                    a_alt          = d1 - (d2 + d0) + one;
                    p_side_next.ms = SLOT_Y;
                    v[0] = VS'(mat_reg[6]) - VS'(mat_reg[2]);
                    v[1] = VS'(mat_reg[3]) + VS'(mat_reg[1]);
                    v[2] = VS'(mat_reg[5]) + VS'(mat_reg[7]);
                end
                default:
                begin
                    a_alt          = d2 - (d0 + d1) + one;
                    p_side_next.ms = SLOT_Z;
                    v[0] = VS'(mat_reg[1]) - VS'(mat_reg[3]);
                    v[1] = VS'(mat_reg[6]) + VS'(mat_reg[2]);
                    v[2] = VS'(mat_reg[7]) + VS'(mat_reg[5]);
                end
            endcase
            // Clamp a non-positive argument to the smallest code
            if (a_alt <= 0)
            begin
                p_a_next          = AW'(1);
                p_side_next.degen = 1'b1;
            end
            else
                p_a_next = a_alt;
        end

        for (int l = 0; l < 3; l++)
        begin
            p_side_next.neg[l] = v[l][VS-1];
            av = v[l][VS-1] ? -v[l] : v[l];
            p_side_next.mag[l*MW +: MW] = av[MW-1:0];
        end
    end

    // Square root, one root bit per stage
    always_comb
    begin
        logic [NP-1:0]  n_in;
        logic [SRW-1:0] rem_in;
        logic [RW-1:0]  root_in;
        logic [SRW-1:0] rem_sh;
        logic [SRW-1:0] trial;

        for (int k = 0; k < RW; k++)
        begin
            if (k == 0)
            begin
                n_in    = NP'({p_a_reg, {FB{1'b0}}});
                rem_in  = '0;
                root_in = '0;
            end
            else
            begin
                n_in    = sq_n_reg[k-1];
                rem_in  = sq_rem_reg[k-1];
                root_in = sq_root_reg[k-1];
            end
            rem_sh = {rem_in[SRW-3:0], n_in[NP-1 -: 2]};
            trial  = SRW'({root_in, 2'b01});
            if (rem_sh >= trial)
            begin
                sq_rem_next[k]  = rem_sh - trial;
                sq_root_next[k] = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = rem_sh;
                sq_root_next[k] = {root_in[RW-2:0], 1'b0};
            end
            sq_n_next[k] = n_in << 2;
        end
    end

    // Restoring division by 2r, one quotient bit per stage, three lanes
    always_comb
    begin
        dv_side_t      side_in;
        logic [DW-1:0] num_in;
        logic [VW:0]   rem_in;
        logic [DW-1:0] quo_in;
        logic [VW:0]   rem_sh;
        logic [VW:0]   divisor;

        for (int t = 0; t < DW; t++)
        begin
            if (t == 0)
            begin
                side_in.ms    = sq_side_reg[RW-1].ms;
                side_in.degen = sq_side_reg[RW-1].degen;
                side_in.neg   = sq_side_reg[RW-1].neg;
                side_in.root  = sq_root_reg[RW-1];
            end
            else
                side_in = dv_side_reg[t-1];
            dv_side_next[t] = side_in;
            divisor = {1'b0, side_in.root, 1'b0};
            for (int l = 0; l < 3; l++)
            begin
                if (t == 0)
                begin
                    num_in = {sq_side_reg[RW-1].mag[l*MW +: MW], {FB{1'b0}}};
                    rem_in = '0;
                    quo_in = '0;
                end
                else
                begin
                    num_in = dv_num_reg[t-1][l];
                    rem_in = dv_rem_reg[t-1][l];
                    quo_in = dv_quo_reg[t-1][l];
                end
                rem_sh = {rem_in[VW-1:0], num_in[DW-1]};
                if (rem_sh >= divisor)
                begin
                    dv_rem_next[t][l] = rem_sh - divisor;
                    dv_quo_next[t][l] = {quo_in[DW-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[t][l] = rem_sh;
                    dv_quo_next[t][l] = {quo_in[DW-2:0], 1'b0};
                end
                dv_num_next[t][l] = num_in << 1;
            end
        end
    end

    // Route the main component and the three lanes to w, x, y, z
    always_comb
    begin
        dv_side_t   side;
        logic [1:0] lane;

        side = dv_side_reg[DW-1];
        for (int p = 0; p < 4; p++)
        begin
            lane = (2'(p) > side.ms) ? 2'(p - 1) : 2'(p);
            if (2'(p) == side.ms)
                out_data_next[p*EW +: EW] = sat_val(1'b0, XW'(side.root >> 1));
            else
                out_data_next[p*EW +: EW] =
                    sat_val(side.neg[lane], XW'(dv_quo_reg[DW-1][lane]));
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < RW; k++)
                sq_vld_reg[k] <= 1'b0;
            for (int t = 0; t < DW; t++)
                dv_vld_reg[t] <= 1'b0;
        end
        else if (ce)
        begin
            in_vld_reg    <= s_tvalid;
            p_vld_reg     <= in_vld_reg;
            sq_vld_reg[0] <= p_vld_reg;
            for (int k = 1; k < RW; k++)
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            dv_vld_reg[0] <= sq_vld_reg[RW-1];
            for (int t = 1; t < DW; t++)
                dv_vld_reg[t] <= dv_vld_reg[t-1];
            out_vld_reg   <= dv_vld_reg[DW-1];
        end
    end

    // Payload, advanced together with the valid bits
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int e = 0; e < 9; e++)
                mat_reg[e] <= s_tdata[e*EW +: EW];
            p_a_reg    <= p_a_next;
            p_side_reg <= p_side_next;
            for (int k = 0; k < RW; k++)
            begin
                sq_n_reg[k]    <= sq_n_next[k];
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
                sq_side_reg[k] <= (k == 0) ? p_side_reg : sq_side_reg[k-1];
            end
            for (int t = 0; t < DW; t++)
            begin
                dv_side_reg[t] <= dv_side_next[t];
                for (int l = 0; l < 3; l++)
                begin
                    dv_num_reg[t][l] <= dv_num_next[t][l];
                    dv_rem_reg[t][l] <= dv_rem_next[t][l];
                    dv_quo_reg[t][l] <= dv_quo_next[t][l];
                end
            end
            out_data_reg <= out_data_next;
            out_user_reg <= dv_side_reg[DW-1].degen;
        end
    end

    `RMQ_ASSERT_IMPLIES(a_trace_no_degen, p_vld_reg && p_side_reg.ms == SLOT_W, !p_side_reg.degen, "degenerate flag raised in trace branch")
    `RMQ_ASSERT_IMPLIES(a_root_nonzero, sq_vld_reg[RW-1], sq_root_reg[RW-1] != '0, "square root result is zero")
    `RMQ_ASSERT_IMPLIES(a_ready_when_empty, !out_vld_reg, s_tready, "input stalled with empty output register")
    `RMQ_ASSERT_NEXT(a_item_enters, s_tvalid && s_tready, in_vld_reg, "accepted item lost at input register")

endmodule
